// ===== design/fpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpc_pkg - shared types and constants of the four-packed-code line encoder
// Item kinds, result status codes, the sequencer states and the base-85
// character map used by the encoder and its divider unit.
// ----------------------------------------------------------------------------
package fpc_pkg;

    // default line data limit
    localparam int unsigned DEF_MAX_LINE_DATA = 248;

    // highest end address a line may reach
    localparam logic [32:0] LIMIT_64K = 33'h1_0000;

    // divide by 85: q = (w * RECIP_85) >> RECIP_SHIFT is exact for 32-bit w
    localparam logic [31:0] RECIP_85    = 32'd3233857729;
    localparam int unsigned RECIP_SHIFT = 38;
    localparam logic [6:0]  B85_DIVISOR = 7'd85;

    // character for digit zero
    localparam logic [6:0] CHAR_PCT = 7'd37;

    // item kinds
    typedef enum logic [1:0] {
        KIND_BEGIN = 2'd0,
        KIND_DATA  = 2'd1,
        KIND_END   = 2'd2,
        KIND_START = 2'd3
    } t_kind;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_TOO_LONG   = 2'd1,
        ST_BEYOND_64K = 2'd2
    } t_status;

    // which group of a line is being produced
    typedef enum logic [1:0] {
        G_HDR0 = 2'd0,
        G_HDR1 = 2'd1,
        G_DATA = 2'd2
    } t_grp;

    // line sequencer states
    typedef enum logic [2:0] {
        S_IDLE = 3'd0,
        S_HDR  = 3'd1,
        S_WAIT = 3'd2,
        S_RD   = 3'd3,
        S_CAP  = 3'd4
    } t_state;

    // five characters, element 4 is the most significant
    typedef logic [4:0][6:0] t_chars;

    // divider unit status towards the sequencer
    typedef struct packed {
        logic   done;
        t_chars chars;
    } t_div_out;

    // base-85 digit to character, skipping '*'
    function automatic logic [6:0] b85_char(input logic [6:0] k);
        return (k < 7'd5) ? (k + 7'd37) : (k + 7'd38);
    endfunction

endpackage

// ===== design/fpc_line_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpc_line_mem - line data store
// Single write port, single registered read port holding the data bytes of
// the line being assembled.
// ----------------------------------------------------------------------------
module fpc_line_mem #(
    parameter int unsigned DEPTH = 248,
    parameter int unsigned AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    // write one byte
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/fpc_div85.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpc_div85 - iterative base-85 digit unit
// Splits a 32-bit word into five base-85 characters, least significant
// digit first, each by a reciprocal multiply, then a remainder step.
// ----------------------------------------------------------------------------
module fpc_div85
    import fpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic [31:0] i_word,
    output t_div_out    o_div
);

    localparam int unsigned QW = 64 - RECIP_SHIFT;

    logic          r_busy;
    logic          r_sub;
    logic [2:0]    r_cnt;
    logic          r_done;
    logic [31:0]   r_w;
    logic [63:0]   r_prod;
    t_chars        r_chars;

    logic [QW-1:0] w_quot;
    logic [6:0]    w_qx85;
    logic [6:0]    w_diff;

    // quotient from the registered product, remainder by back-multiply
    // (the remainder is below 128, so seven bits of the product suffice)
    assign w_quot = r_prod[63:RECIP_SHIFT];
    assign w_qx85 = w_quot[6:0] * B85_DIVISOR;
    assign w_diff = r_w[6:0] - w_qx85;

    // sequence the five digit steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_sub  <= 1'b0;
            r_cnt  <= 3'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_sub  <= 1'b0;
                r_cnt  <= 3'd0;
            end else if (r_busy) begin
                if (!r_sub) begin
                    r_sub <= 1'b1;
                end else begin
                    r_sub <= 1'b0;
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == 3'd4) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end

    // multiply, then take the digit and carry the quotient forward
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_w <= i_word;
        end else if (r_busy && !r_sub) begin
            r_prod <= r_w * RECIP_85;
        end else if (r_busy && r_sub) begin
            r_w     <= {{(32-QW){1'b0}}, w_quot};
            r_chars <= {b85_char(w_diff), r_chars[4:1]};
        end
    end

    assign o_div.done  = r_done;
    assign o_div.chars = r_chars;

endmodule

// ===== design/four_packed_code_line_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_packed_code_line_encoder - base-85 load file line encoder
// Collects a line of data bytes, then emits its header and data as groups
// of five base-85 characters; also emits start-address records.
// ----------------------------------------------------------------------------
//  channel   | handshake                | payload
//  ----------+--------------------------+-------------------------------------
//  item in   | start / busy             | i_kind, i_address, i_data_byte
//  result    | o_strobe (one cycle)     | o_char_one..five, o_line_start,
//            |                          | o_line_end, o_last, o_status
//  config    | i_cfg_we                 | i_cfg_data (suppress start record)
//
//  Begin and data-byte items do not raise busy, nor do error results and the
//  start record at address zero. A line holds busy over its two header groups
//  and each data group; a data group takes four reads of the line store, a pass
//  through the shared divide-by-85 unit and a step to take its digits. A start
//  record at a nonzero address is a data-less line.
//  Reset clears the line state and the register; the store needs no clear.
//  Results cannot be stalled; busy is high while a line is being emitted.
// ----------------------------------------------------------------------------
module four_packed_code_line_encoder
    import fpc_pkg::*;
#(
    parameter int unsigned MAX_LINE_DATA = DEF_MAX_LINE_DATA
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_address,
    input  logic [7:0]  i_data_byte,
    input  logic        i_cfg_we,
    input  logic        i_cfg_data,
    output logic        o_strobe,
    output logic [6:0]  o_char_one,
    output logic [6:0]  o_char_two,
    output logic [6:0]  o_char_three,
    output logic [6:0]  o_char_four,
    output logic [6:0]  o_char_five,
    output logic        o_line_start,
    output logic        o_line_end,
    output logic        o_last,
    output logic [1:0]  o_status
);

    localparam int unsigned AW = $clog2(MAX_LINE_DATA);
    localparam int unsigned CW = $clog2(MAX_LINE_DATA + 1);
    localparam int unsigned IW = $clog2(MAX_LINE_DATA + 4);

    // control
    t_state          r_state, n_state;
    logic            r_suppress;
    logic [CW-1:0]   r_count;
    logic            r_ovf;
    logic            r_strobe;
    t_grp            r_gsel;
    logic            r_last_grp;
    logic [IW-1:0]   r_idx;
    logic [1:0]      r_bsel;

    // payload
    logic [31:0]     r_line_addr;
    logic [7:0]      r_sum;
    logic [31:0]     r_em_addr;
    logic [CW-1:0]   r_em_count;
    logic [7:0]      r_em_sum;
    logic [31:0]     r_word;
    t_chars          r_chars;
    logic            r_start_f;
    logic            r_end_f;
    logic            r_last_f;
    logic [1:0]      r_status;

    logic            w_accept;
    t_kind           w_kind;
    logic            w_full;
    logic            w_beyond;
    logic            w_we;
    logic [7:0]      w_rdata;
    logic [7:0]      w_byte;
    logic [7:0]      w_len;
    logic [7:0]      w_hsum;
    logic [7:0]      w_ck;
    logic            w_go;
    logic [31:0]     w_go_word;
    t_div_out        w_div;
    logic            w_out_load;
    t_chars          w_out_chars;
    logic            w_out_start;
    logic            w_out_end;
    t_status         w_out_status;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_kind   = t_kind'(i_kind);
    assign w_full   = (r_count == CW'(MAX_LINE_DATA));
    assign w_beyond = ({1'b0, r_line_addr} + 33'(r_count)) > LIMIT_64K;
    assign w_we     = w_accept && (w_kind == KIND_DATA) && !w_full;

    // header bytes: length and negated byte sum
    assign w_len  = 8'(r_em_count) + 8'd4;
    assign w_hsum = r_em_sum + w_len + r_em_addr[31:24] + r_em_addr[23:16]
                  + r_em_addr[15:8] + r_em_addr[7:0];
    assign w_ck   = 8'd0 - w_hsum;

    // zero the padding past the end of the data
    assign w_byte = (r_idx < IW'(r_em_count)) ? w_rdata : 8'd0;

    fpc_line_mem #(
        .DEPTH (MAX_LINE_DATA),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_data_byte),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    fpc_div85 u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_go),
        .i_word  (w_go_word),
        .o_div   (w_div)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && (w_kind == KIND_END) && !r_ovf && !w_beyond) begin
                    n_state = S_HDR;
                end else if (w_accept && (w_kind == KIND_START) && !r_suppress
                             && (i_address != 32'd0)) begin
                    n_state = S_HDR;
                end
            end
            S_HDR: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (w_div.done) begin
                    if (r_last_grp) begin
                        n_state = S_IDLE;
                    end else if (r_gsel != G_HDR0) begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                n_state = S_CAP;
            end
            S_CAP: begin
                if (r_bsel == 2'd3) begin
                    n_state = S_WAIT;
                end else begin
                    n_state = S_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // divider launches and result loads
    always_comb begin
        w_go         = 1'b0;
        w_go_word    = {w_ck, w_len, 16'h0000};
        w_out_load   = 1'b0;
        w_out_chars  = w_div.chars;
        w_out_start  = 1'b0;
        w_out_end    = 1'b0;
        w_out_status = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (w_accept && (w_kind == KIND_END)) begin
                    if (r_ovf) begin
                        w_out_load   = 1'b1;
                        w_out_chars  = '0;
                        w_out_status = ST_TOO_LONG;
                    end else if (w_beyond) begin
                        w_out_load   = 1'b1;
                        w_out_chars  = '0;
                        w_out_status = ST_BEYOND_64K;
                    end
                end else if (w_accept && (w_kind == KIND_START) && !r_suppress
                             && (i_address == 32'd0)) begin
                    w_out_load  = 1'b1;
                    w_out_chars = {5{CHAR_PCT}};
                    w_out_start = 1'b1;
                    w_out_end   = 1'b1;
                end
            end
            S_HDR: begin
                w_go = 1'b1;
            end
            S_WAIT: begin
                if (w_div.done) begin
                    w_out_load  = 1'b1;
                    w_out_start = (r_gsel == G_HDR0);
                    w_out_end   = r_last_grp;
                    if (!r_last_grp && (r_gsel == G_HDR0)) begin
                        w_go      = 1'b1;
                        w_go_word = r_em_addr;
                    end
                end
            end
            S_CAP: begin
                if (r_bsel == 2'd3) begin
                    w_go      = 1'b1;
                    w_go_word = {r_word[23:0], w_byte};
                end
            end
            default: begin
                w_go = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_suppress <= 1'b0;
            r_count    <= '0;
            r_ovf      <= 1'b0;
            r_strobe   <= 1'b0;
            r_gsel     <= G_HDR0;
            r_last_grp <= 1'b0;
            r_idx      <= '0;
            r_bsel     <= 2'd0;
        end else begin
            r_state  <= n_state;
            r_strobe <= w_out_load;
            if (i_cfg_we) begin
                r_suppress <= i_cfg_data;
            end
            // line collection
            if (w_accept) begin
                case (w_kind)
                    KIND_BEGIN, KIND_END: begin
                        r_count <= '0;
                        r_ovf   <= 1'b0;
                    end
                    KIND_DATA: begin
                        if (w_full) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_count <= r_count + CW'(1);
                        end
                    end
                    default: begin
                        r_ovf <= r_ovf;
                    end
                endcase
            end
            // group walk
            if (r_state == S_HDR) begin
                r_gsel     <= G_HDR0;
                r_last_grp <= 1'b0;
                r_idx      <= '0;
                r_bsel     <= 2'd0;
            end else if ((r_state == S_WAIT) && w_div.done) begin
                if (r_gsel == G_HDR0) begin
                    r_gsel     <= G_HDR1;
                    r_last_grp <= (r_em_count == '0);
                end else begin
                    r_gsel <= G_DATA;
                end
            end else if (r_state == S_CAP) begin
                r_idx  <= r_idx + IW'(1);
                r_bsel <= r_bsel + 2'd1;
                if (r_bsel == 2'd3) begin
                    r_last_grp <= ((r_idx + IW'(1)) >= IW'(r_em_count));
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_addr <= 32'd0;
            r_sum       <= 8'd0;
        end else if (w_accept) begin
            case (w_kind)
                KIND_BEGIN: begin
                    r_line_addr <= i_address;
                    r_sum       <= 8'd0;
                end
                KIND_DATA: begin
                    if (!w_full) begin
                        r_sum <= r_sum + i_data_byte;
                    end
                end
                KIND_END: begin
                    r_sum <= 8'd0;
                end
                default: begin
                    r_sum <= r_sum;
                end
            endcase
        end
    end

    // snapshot the line to emit, assemble data words, hold the result
    always_ff @(posedge i_clk) begin
        if (w_accept && (w_kind == KIND_END)) begin
            r_em_addr  <= r_line_addr;
            r_em_count <= r_count;
            r_em_sum   <= r_sum;
        end else if (w_accept && (w_kind == KIND_START)) begin
            r_em_addr  <= i_address;
            r_em_count <= '0;
            r_em_sum   <= 8'd0;
        end
        if (r_state == S_CAP) begin
            r_word <= {r_word[23:0], w_byte};
        end
        if (w_out_load) begin
            r_chars   <= w_out_chars;
            r_start_f <= w_out_start;
            r_end_f   <= w_out_end;
            r_last_f  <= w_out_end || (w_out_status != ST_OK);
            r_status  <= w_out_status;
        end
    end

    assign o_strobe     = r_strobe;
    assign o_char_one   = r_chars[4];
    assign o_char_two   = r_chars[3];
    assign o_char_three = r_chars[2];
    assign o_char_four  = r_chars[1];
    assign o_char_five  = r_chars[0];
    assign o_line_start = r_start_f;
    assign o_line_end   = r_end_f;
    assign o_last       = r_last_f;
    assign o_status     = r_status;

endmodule

// ===== design/fpc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpc_checker - port-level checks of the line encoder
// Watches the top-level ports for result shape and strobe timing.
// ----------------------------------------------------------------------------
module fpc_checker
    import fpc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  i_kind,
    input logic        o_strobe,
    input logic [6:0]  o_char_one,
    input logic [6:0]  o_char_two,
    input logic [6:0]  o_char_three,
    input logic [6:0]  o_char_four,
    input logic [6:0]  o_char_five,
    input logic        o_line_start,
    input logic        o_line_end,
    input logic        o_last,
    input logic [1:0]  o_status
);

    // an error transaction is a single blank result
    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status != ST_OK)) |->
        (o_last && !o_line_start && !o_line_end && (o_char_one == 7'd0)
         && (o_char_five == 7'd0)))
        else $error("error result not blank");

    // a line always closes on the final result of its item
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_line_end) |-> o_last)
        else $error("line end without last");

    // begin and data items produce nothing
    a_silent_items: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && ((i_kind == KIND_BEGIN) || (i_kind == KIND_DATA)))
        |=> !o_strobe)
        else $error("result after begin or data item");

    // reset drops the strobe and busy
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_strobe && !busy))
        else $error("activity after reset");

endmodule

bind four_packed_code_line_encoder fpc_checker u_fpc_checker (.*);
